FILE: rtl/coordinate_keyed_overlay_table_assert.svh
// Assertion macros shared by the table modules.
`ifndef COORDINATE_KEYED_OVERLAY_TABLE_ASSERT_SVH
`define COORDINATE_KEYED_OVERLAY_TABLE_ASSERT_SVH

`ifndef SYNTH

// Clocked assertion that is switched off while reset is asserted.
`define CKOT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CKOT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CKOT_ASSERT(label, clk, rst_n, prop, msg)
`define CKOT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: rtl/ckot_pkg.sv
`default_nettype none

package ckot_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam logic [7:0] EMPTY_MARK = 8'hFF;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [7:0] value;
        logic       empty_seen;
    } tok_t;

    // Current transaction, broadcast to every cell.
    typedef struct packed {
        logic               op;
        logic signed [15:0] key_x;
        logic        [7:0]  key_y;
        logic signed [15:0] key_z;
        logic        [7:0]  new_value;
    } qry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/ckot_cell.sv
`default_nettype none

`include "coordinate_keyed_overlay_table_assert.svh"

module ckot_cell
    import ckot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire tok_t tok_in,
    input  wire qry_t query,
    input  wire logic fill,
    output tok_t      tok_out
);

    logic signed [15:0] key_x_reg;
    logic        [7:0]  key_y_reg;
    logic signed [15:0] key_z_reg;
    logic        [7:0]  value_reg;
    logic        [7:0]  value_next;
    logic               mark_reg;
    logic               mark_next;
    tok_t               tok_reg;
    tok_t               tok_next;

    logic occupied;
    logic key_match;
    logic hit_here;
    logic fill_here;

    assign occupied  = (value_reg != EMPTY_MARK);
    assign key_match = occupied && (key_x_reg == query.key_x) &&
                       (key_y_reg == query.key_y) && (key_z_reg == query.key_z);
    assign hit_here  = tok_in.valid && !tok_in.hit && key_match;
    assign fill_here = fill && mark_reg;

    always_comb
    begin
        tok_next.valid      = tok_in.valid;
        tok_next.hit        = tok_in.hit | hit_here;
        tok_next.value      = hit_here ? value_reg : tok_in.value;
        tok_next.empty_seen = tok_in.empty_seen | (tok_in.valid & ~occupied);
    end

    // The mark is refreshed on every pass, so after a pass only the lowest
    // cell that the token found empty carries it, if there is one.
    always_comb
    begin
        mark_next = mark_reg;
        if (tok_in.valid)
        begin
            mark_next = !tok_in.empty_seen && !occupied;
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (hit_here && (query.op == OP_WRITE))
        begin
            value_next = query.new_value;
        end
        else if (fill_here)
        begin
            value_next = query.new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= EMPTY_MARK;
            mark_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            value_reg <= value_next;
            mark_reg  <= mark_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_here)
        begin
            key_x_reg <= query.key_x;
            key_y_reg <= query.key_y;
            key_z_reg <= query.key_z;
        end
    end

    assign tok_out = tok_reg;

    `CKOT_ASSERT(a_value_quiet, clk, rst_n, (!tok_in.valid && !fill) |=> $stable(value_reg), "cell value changed without a token or a fill")
    `CKOT_ASSERT(a_fill_empty, clk, rst_n, fill_here |-> !occupied, "fill targeted an occupied cell")
    `CKOT_ASSERT(a_hit_sticky, clk, rst_n, (tok_in.valid && tok_in.hit) |=> tok_out.hit, "hit flag dropped along the row")

endmodule

`default_nettype wire

FILE: rtl/coordinate_keyed_overlay_table.sv
// One transaction at a time: a token walks the row of cells one cell per cycle, and a
// new transaction is taken only after it has left the row and its result has moved
// to the output register, which waits while a held result is not taken (m_tready low).
// Reset (rst_n low, asynchronous) empties every entry; keys are loaded only on fill.
`default_nettype none

`include "coordinate_keyed_overlay_table_assert.svh"

module coordinate_keyed_overlay_table
    import ckot_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // key_x [15:0], key_y [23:16], key_z [39:24], new_value [47:40]
    input  wire logic [47:0] s_tdata,
    // op [0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found_value [7:0]
    output logic [7:0]       m_tdata,
    // table_full [0]
    output logic [0:0]       m_tuser
);

    state_t     state_reg;
    state_t     state_next;
    qry_t       query_reg;
    logic       inj_valid_reg;
    logic [7:0] res_value_reg;
    logic       res_full_reg;
    logic       out_valid_reg;
    logic [7:0] out_value_reg;
    logic       out_full_reg;

    logic s_accept;
    logic out_free;
    logic load_out;
    logic fill;
    tok_t tail;
    tok_t chain_tok [TABLE_DEPTH+1];

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign tail     = chain_tok[TABLE_DEPTH];

    // A write with no match fills the lowest empty cell while the token leaves.
    assign fill = tail.valid && (query_reg.op == OP_WRITE) && !tail.hit && tail.empty_seen;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                s_tready = 1'b0;
            end
            ST_WAIT:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inj_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_valid_reg <= s_accept;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            query_reg.op        <= s_tuser[0];
            query_reg.key_x     <= s_tdata[15:0];
            query_reg.key_y     <= s_tdata[23:16];
            query_reg.key_z     <= s_tdata[39:24];
            query_reg.new_value <= s_tdata[47:40];
        end
        if (tail.valid)
        begin
            res_value_reg <= (query_reg.op == OP_WRITE) ? 8'h00 : tail.value;
            res_full_reg  <= (query_reg.op == OP_WRITE) && !tail.hit && !tail.empty_seen;
        end
        if (load_out)
        begin
            out_value_reg <= res_value_reg;
            out_full_reg  <= res_full_reg;
        end
    end

    assign chain_tok[0] = '{valid: inj_valid_reg, hit: 1'b0, value: EMPTY_MARK,
                            empty_seen: 1'b0};

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ckot_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain_tok[i]),
            .query   (query_reg),
            .fill    (fill),
            .tok_out (chain_tok[i+1])
        );
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_full_reg;

    `CKOT_ASSERT(a_tail_in_scan, clk, rst_n, tail.valid |-> (state_reg == ST_SCAN), "token left the row outside a scan")
    `CKOT_ASSERT(a_fill_on_write, clk, rst_n, fill |-> (query_reg.op == OP_WRITE), "fill raised for a lookup")
    `CKOT_ASSERT(a_accept_scan, clk, rst_n, s_accept |=> (state_reg == ST_SCAN) && inj_valid_reg, "accepted transaction did not start a scan")
    `CKOT_ASSERT(a_full_zero, clk, rst_n, (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h00), "table full reported with a nonzero value")

endmodule

`default_nettype wire

FILE: verif/coordinate_keyed_overlay_table_checker.sv
`timescale 1ns / 1ps

module coordinate_keyed_overlay_table_checker
    import ckot_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // key_x [15:0], key_y [23:16], key_z [39:24], new_value [47:40]
    input  wire logic [47:0] s_tdata,
    // op [0]
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // found_value [7:0]
    input  wire logic [7:0]  m_tdata,
    // table_full [0]
    input  wire logic [0:0]  m_tuser,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [7:0] found_value;
        logic       table_full;
    } overlay_result_t;

    // Keys are kept as one raw 40-bit pattern {z, y, x}, so equality matches
    // the signed comparison of each coordinate.
    logic [39:0]     slot_key [DEPTH];
    logic [7:0]      slot_val [DEPTH];
    int              fill_mark;
    overlay_result_t pending_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        fill_mark   = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_key[i] = '0;
            slot_val[i] = EMPTY_MARK;
        end
    end

    function automatic overlay_result_t apply_table_op(input logic op,
                                                       input logic [39:0] key,
                                                       input logic [7:0] value);
        overlay_result_t res;
        bit              done;
        res.found_value = (op == OP_LOOKUP) ? EMPTY_MARK : 8'd0;
        res.table_full  = 1'b0;
        done            = 1'b0;
        // Only entries below the mark are searched for a matching key.
        for (int slot = 0; slot < fill_mark && !done; slot++)
        begin
            if (slot_val[slot] != EMPTY_MARK && slot_key[slot] == key)
            begin
                done = 1'b1;
                if (op == OP_LOOKUP)
                    res.found_value = slot_val[slot];
                else
                    slot_val[slot] = value;
            end
        end
        if (op == OP_WRITE && !done)
        begin
            for (int slot = 0; slot < DEPTH && !done; slot++)
            begin
                if (slot_val[slot] == EMPTY_MARK)
                begin
                    slot_key[slot] = key;
                    slot_val[slot] = value;
                    if (slot >= fill_mark)
                        fill_mark = slot + 1;
                    done = 1'b1;
                end
            end
            if (!done)
                res.table_full = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        overlay_result_t want;
        if (rst_n)
        begin
            // Results are checked before new inputs are predicted, so a stray
            // result can never be paired with its own transaction.
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result found_value %0d table_full %0d",
                                 $realtime, m_tdata, m_tuser);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.found_value || m_tuser[0] !== want.table_full)
                    begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch: expected found_value %0d table_full %0d, got found_value %0d table_full %0d",
                                     $realtime, want.found_value, want.table_full,
                                     m_tdata, m_tuser);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_table_op(s_tuser[0], s_tdata[39:0],
                                                         s_tdata[47:40]));
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: verif/coordinate_keyed_overlay_table_tb.sv
`timescale 1ns / 1ps

module coordinate_keyed_overlay_table_tb;
    import ckot_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = OP_LOOKUP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    int          mismatches;
    int          outstanding;

    // Once set, neither side idles any more.
    bit          quiet = 1'b0;
    int          ready_hold = 0;
    logic [39:0] key_pool [$];

    coordinate_keyed_overlay_table #(.TABLE_DEPTH(DEPTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    coordinate_keyed_overlay_table_checker #(.DEPTH(DEPTH)) table_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("coordinate_keyed_overlay_table_tb: FAIL");
        $finish;
    end

    // Result side: random stalls alternate with random ready stretches until quiet is set.
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold = ready_hold - 1;
        else if (m_tready)
        begin
            m_tready   <= 1'b0;
            ready_hold = $urandom_range(1, 19) - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold = $urandom_range(1, 60) - 1;
        end
    end

    function automatic logic [39:0] make_key(input logic [15:0] x, input logic [7:0] y,
                                             input logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [39:0] fresh_key();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[39:0];
    endfunction

    function automatic logic [39:0] pooled_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    task automatic send_op(input logic op, input logic [39:0] key, input logic [7:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {value, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [39:0] k_lo;
        logic [39:0] k_hi;
        logic [39:0] k_neg;
        logic [39:0] k_zero;
        logic [39:0] key;
        logic [7:0]  value;
        logic        op;
        int          pick;

        k_lo   = make_key(16'h8000, 8'd0, 16'h7FFF);
        k_hi   = make_key(16'h7FFF, 8'd255, 16'h8000);
        k_neg  = make_key(16'hFFFF, 8'd128, 16'h0000);
        k_zero = make_key(16'h0000, 8'd0, 16'h0000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table lookup, extreme keys, near-miss keys, emptying a
        // matched entry, a write of the empty value with no match, refilling a
        // slot below the mark and updating an existing entry.
        send_op(OP_LOOKUP, k_lo, 8'd0);
        send_op(OP_WRITE,  k_lo, 8'd0);
        send_op(OP_LOOKUP, k_lo, 8'd0);
        send_op(OP_WRITE,  k_hi, 8'd254);
        send_op(OP_LOOKUP, k_hi, 8'd0);
        send_op(OP_LOOKUP, make_key(16'h7FFF, 8'd254, 16'h8000), 8'd0);
        send_op(OP_LOOKUP, make_key(16'h7FFE, 8'd255, 16'h8000), 8'd0);
        send_op(OP_LOOKUP, make_key(16'h7FFF, 8'd255, 16'h8001), 8'd0);
        send_op(OP_WRITE,  k_lo, EMPTY_MARK);
        send_op(OP_LOOKUP, k_lo, 8'd0);
        send_op(OP_WRITE,  k_neg, EMPTY_MARK);
        send_op(OP_LOOKUP, k_neg, 8'd0);
        send_op(OP_WRITE,  k_zero, 8'd7);
        send_op(OP_LOOKUP, k_zero, 8'd0);
        send_op(OP_WRITE,  k_hi, 8'd1);
        send_op(OP_LOOKUP, k_hi, 8'd0);
        send_op(OP_WRITE,  k_lo, 8'd200);
        send_op(OP_LOOKUP, k_lo, 8'd0);
        send_op(OP_LOOKUP, make_key(16'h0000, 8'd0, 16'hFFFF), 8'd0);
        send_op(OP_WRITE,  k_neg, 8'd99);
        send_op(OP_LOOKUP, k_neg, 8'd0);
        key_pool.push_back(k_lo);
        key_pool.push_back(k_hi);
        key_pool.push_back(k_neg);
        key_pool.push_back(k_zero);

        // Fill: mostly writes of new keys, enough to run the table out of slots.
        for (int n = 0; n < 300; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_op(OP_LOOKUP, pooled_key(), 8'($urandom));
            else
            begin
                key   = fresh_key();
                value = ($urandom_range(0, 19) == 0) ? EMPTY_MARK
                                                     : 8'($urandom_range(0, 254));
                key_pool.push_back(key);
                send_op(OP_WRITE, key, value);
            end
        end

        // Mixed traffic on a full or nearly full table: hits, updates, freeing
        // entries, refills, near-miss keys and writes that find no room.
        for (int n = 0; n < 530; n++)
        begin
            if (n == 430)
                quiet = 1'b1;
            op   = $urandom_range(0, 1) ? OP_WRITE : OP_LOOKUP;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                key = pooled_key();
            else if (pick < 7)
                key = pooled_key() ^ (40'd1 << $urandom_range(0, 39));
            else
                key = fresh_key();
            value = ($urandom_range(0, 6) == 0) ? EMPTY_MARK : 8'($urandom);
            if (op == OP_WRITE && pick >= 7)
                key_pool.push_back(key);
            send_op(op, key, value);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
        if (mismatches == 0)
            $display("coordinate_keyed_overlay_table_tb: PASS");
        else
            $display("coordinate_keyed_overlay_table_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ckot_pkg.sv
rtl/ckot_cell.sv
rtl/coordinate_keyed_overlay_table.sv
verif/coordinate_keyed_overlay_table_checker.sv
verif/coordinate_keyed_overlay_table_tb.sv
